// ----- rtl/pns_pkg.sv -----
package pns_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = 24;
    localparam int AMP_FRAC  = 16;
    localparam int TBL_AW    = 8;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int PERM_W    = 8;
    localparam int POS_W     = 40;
    localparam int OFF_W     = 24;
    localparam int ACC_W     = 48;
    localparam int NOISE_W   = 27;
    localparam int SUM_W     = POS_W + 1;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD      = 2'd0;
    localparam cmd_t CMD_SAMPLE_3D = 2'd1;
    localparam cmd_t CMD_SAMPLE_2D = 2'd2;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [27:0] mix_t;
    typedef logic signed [25:0] coord_t;
    typedef logic [Q_BITS-1:0]  frac_t;
    typedef logic [TBL_AW-1:0]  tidx_t;

    localparam word_t FADE_K15 = word_t'(15 * (2 ** Q_BITS));
    localparam word_t FADE_K10 = word_t'(10 * (2 ** Q_BITS));
    localparam coord_t ONE_Q   = coord_t'(2 ** Q_BITS);

    // micro-operations in sequencer order; each enabled one has an issue and a writeback step
    typedef enum logic [5:0] {
        UOP_FX_A, UOP_FX_C, UOP_FX_D, UOP_FX_S,
        UOP_FY_A, UOP_FY_C, UOP_FY_D, UOP_FY_S,
        UOP_FZ_A, UOP_FZ_C, UOP_FZ_D, UOP_FZ_S,
        UOP_RD_H0, UOP_RD_H1, UOP_RD_P2, UOP_RD_P3, UOP_RD_P5, UOP_RD_P6,
        UOP_RD_G00, UOP_RD_G01, UOP_MIX_C0,
        UOP_RD_G10, UOP_RD_G11, UOP_MIX_C1,
        UOP_RD_G20, UOP_RD_G21, UOP_MIX_C2,
        UOP_RD_G30, UOP_RD_G31, UOP_MIX_C3,
        UOP_MIX_E0, UOP_MIX_E1, UOP_MIX_N, UOP_SCALE
    } uop_t;

    typedef struct packed {
        logic load_wr;
        logic capture;
        logic is2d;
        uop_t uop;
        logic issue;
        logic wb;
    } ctl_t;

    typedef struct packed {
        logic recomp;
    } dp_status_t;

endpackage

// ----- rtl/pns_ctrl.sv -----
module pns_ctrl
    import pns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  cmd_t       cmd,
    input  logic       out_ready,
    input  dp_status_t status,
    output logic       in_ready,
    output logic       out_valid,
    output ctl_t       ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    uop_t   pc_reg, pc_next;
    logic   phase_reg, phase_next;
    logic   is2d_reg, is2d_next;
    logic   out_valid_reg, out_valid_next;

    logic accept, en, last, out_busy, fire_last, running;

    function automatic logic op_enabled(uop_t u, logic is2d, logic recomp);
        logic r;
        r = 1'b1;
        case (u)
            UOP_FY_A, UOP_FY_C, UOP_FY_D, UOP_FY_S,
            UOP_MIX_E0, UOP_MIX_E1:
                r = !is2d;
            UOP_RD_H0, UOP_RD_H1, UOP_RD_P2, UOP_RD_P5,
            UOP_RD_G00, UOP_RD_G01, UOP_MIX_C0,
            UOP_RD_G20, UOP_RD_G21, UOP_MIX_C2:
                r = is2d | recomp;
            UOP_RD_P3, UOP_RD_P6,
            UOP_RD_G10, UOP_RD_G11, UOP_MIX_C1,
            UOP_RD_G30, UOP_RD_G31, UOP_MIX_C3:
                r = !is2d & recomp;
            default:
                r = 1'b1;
        endcase
        return r;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign running   = (state_reg == ST_RUN);
    assign en        = op_enabled(pc_reg, is2d_reg, status.recomp);
    assign last      = (pc_reg == UOP_SCALE);
    assign out_busy  = out_valid_reg & !out_ready;
    assign fire_last = running & en & phase_reg & last & !out_busy;
    assign out_valid = out_valid_reg;

    assign out_valid_next = out_busy | fire_last;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        is2d_next  = is2d_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_SAMPLE_3D || cmd == CMD_SAMPLE_2D))
                begin
                    state_next = ST_RUN;
                    pc_next    = UOP_FX_A;
                    phase_next = 1'b0;
                    is2d_next  = (cmd == CMD_SAMPLE_2D);
                end
            end
            ST_RUN:
            begin
                if (!en)
                begin
                    pc_next = uop_t'(pc_reg + 6'd1);
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else if (last)
                begin
                    if (!out_busy)
                    begin
                        phase_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    pc_next    = uop_t'(pc_reg + 6'd1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.load_wr = accept & (cmd == CMD_LOAD);
        ctl.capture = accept & (cmd == CMD_SAMPLE_3D || cmd == CMD_SAMPLE_2D);
        ctl.is2d    = in_ready ? (cmd == CMD_SAMPLE_2D) : is2d_reg;
        ctl.uop     = pc_reg;
        ctl.issue   = running & en & !phase_reg;
        ctl.wb      = running & en & phase_reg & (!last | !out_busy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= UOP_FX_A;
            phase_reg     <= 1'b0;
            is2d_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            is2d_reg      <= is2d_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/pns_dp.sv -----
module pns_dp
    import pns_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctl_t                     ctl,
    input  logic [OFF_W-1:0]         offset_x,
    input  logic [OFF_W-1:0]         offset_y,
    input  logic [OFF_W-1:0]         offset_z,
    input  logic [OFF_W-1:0]         inv_amplitude,
    input  logic [7:0]               table_index,
    input  logic [PERM_W-1:0]        table_value,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic                     column_start,
    input  logic signed [ACC_W-1:0]  accum_in,
    output dp_status_t               status,
    output logic signed [ACC_W-1:0]  accum_out,
    output logic signed [NOISE_W-1:0] noise_out
);

    function automatic logic signed [SUM_W-1:0] add_off(logic signed [POS_W-1:0] p,
                                                       logic [OFF_W-1:0] o);
        logic signed [SUM_W-1:0] ps;
        logic signed [SUM_W-1:0] os;
        ps = SUM_W'(p);
        os = $signed(SUM_W'(o));
        return ps + os;
    endfunction

    function automatic mix_t grad_q(logic [3:0] h, coord_t x, coord_t y, coord_t z);
        coord_t u;
        coord_t v;
        mix_t   su;
        mix_t   sv;
        u  = h[3] ? y : x;
        v  = (h[3:2] == 2'b00) ? y : ((h[3:2] == 2'b11 && !h[0]) ? x : z);
        su = h[0] ? -mix_t'(u) : mix_t'(u);
        sv = h[1] ? -mix_t'(v) : mix_t'(v);
        return su + sv;
    endfunction

    logic [PERM_W-1:0] perm_mem [TBL_DEPTH];
    logic [PERM_W-1:0] rdata_reg;

    frac_t  tx_reg, ty_reg, tz_reg;
    tidx_t  cx_reg, cy_reg, cz_reg;
    logic signed [ACC_W-1:0] acc_in_reg;
    tidx_t  last_cy_reg;
    logic   recomp_reg;

    word_t  fb_reg;
    coord_t fc_reg, sx_reg, sy_reg, sz_reg;
    tidx_t  h0_reg, h1_reg, p2_reg, p3_reg, p5_reg, p6_reg;
    mix_t   g0_reg, g1_reg, n0_reg, n1_reg, e0_reg, e1_reg, noise_reg;
    mix_t   cm_reg [4];
    prod_t  prod_reg;
    logic signed [ACC_W-1:0]   accum_out_reg;
    logic signed [NOISE_W-1:0] noise_out_reg;

    logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
    frac_t  tx_next, ty_next, tz_next;
    tidx_t  cy_next;
    logic   recomp_now;

    tidx_t  rd_addr;
    frac_t  tf;
    word_t  tw, six_t, mul_a, mul_b;
    mix_t   la, lb, base, lerp_res;
    prod_t  shifted, scaled;
    logic signed [ACC_W+1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    coord_t x0, x1, y0, y1, z0, z1, gx, gy, gz;
    mix_t   grad_val;

    // split into cell and fraction
    assign sum_x   = add_off(pos_x, offset_x);
    assign sum_y   = add_off(pos_y, offset_y);
    assign sum_z   = add_off(pos_z, offset_z);
    assign tx_next = frac_t'(sum_x[FRAC_BITS-1:0]) << (Q_BITS - FRAC_BITS);
    assign ty_next = frac_t'(sum_y[FRAC_BITS-1:0]) << (Q_BITS - FRAC_BITS);
    assign tz_next = frac_t'(sum_z[FRAC_BITS-1:0]) << (Q_BITS - FRAC_BITS);
    assign cy_next = sum_y[FRAC_BITS +: TBL_AW];
    assign recomp_now = column_start | (cy_next != last_cy_reg);

    assign status.recomp = recomp_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            tx_reg     <= tx_next;
            tz_reg     <= tz_next;
            cx_reg     <= sum_x[FRAC_BITS +: TBL_AW];
            cz_reg     <= sum_z[FRAC_BITS +: TBL_AW];
            ty_reg     <= ctl.is2d ? '0 : ty_next;
            cy_reg     <= ctl.is2d ? '0 : cy_next;
            acc_in_reg <= accum_in;
        end
    end

    // permutation table
    always_ff @(posedge clk)
    begin
        if (ctl.load_wr)
        begin
            perm_mem[tidx_t'(table_index)] <= table_value;
        end
        rdata_reg <= perm_mem[rd_addr];
    end

    always_comb
    begin
        unique case (ctl.uop)
            UOP_RD_H0:  rd_addr = cx_reg;
            UOP_RD_H1:  rd_addr = cx_reg + tidx_t'(1);
            UOP_RD_P2:  rd_addr = h0_reg;
            UOP_RD_P3:  rd_addr = h0_reg + tidx_t'(1);
            UOP_RD_P5:  rd_addr = h1_reg;
            UOP_RD_P6:  rd_addr = h1_reg + tidx_t'(1);
            UOP_RD_G00: rd_addr = p2_reg;
            UOP_RD_G01: rd_addr = p5_reg;
            UOP_RD_G10: rd_addr = p3_reg;
            UOP_RD_G11: rd_addr = p6_reg;
            UOP_RD_G20: rd_addr = p2_reg + tidx_t'(1);
            UOP_RD_G21: rd_addr = p5_reg + tidx_t'(1);
            UOP_RD_G30: rd_addr = p3_reg + tidx_t'(1);
            UOP_RD_G31: rd_addr = p6_reg + tidx_t'(1);
            default:    rd_addr = cx_reg;
        endcase
    end

    // corner gradient
    assign x0 = $signed(coord_t'(tx_reg));
    assign y0 = $signed(coord_t'(ty_reg));
    assign z0 = $signed(coord_t'(tz_reg));
    assign x1 = x0 - ONE_Q;
    assign y1 = y0 - ONE_Q;
    assign z1 = z0 - ONE_Q;

    always_comb
    begin
        gx = x0;
        gy = y0;
        gz = z0;
        unique case (ctl.uop)
            UOP_RD_G01: gx = x1;
            UOP_RD_G10: gy = y1;
            UOP_RD_G11:
            begin
                gx = x1;
                gy = y1;
            end
            UOP_RD_G20: gz = z1;
            UOP_RD_G21:
            begin
                gx = x1;
                gz = z1;
            end
            UOP_RD_G30:
            begin
                gy = y1;
                gz = z1;
            end
            UOP_RD_G31:
            begin
                gx = x1;
                gy = y1;
                gz = z1;
            end
            default:
            begin
                gx = x0;
            end
        endcase
    end

    assign grad_val = grad_q(rdata_reg[3:0], gx, gy, gz);

    // shared multiplier operands
    always_comb
    begin
        unique case (ctl.uop)
            UOP_FX_A, UOP_FX_C, UOP_FX_D, UOP_FX_S: tf = tx_reg;
            UOP_FY_A, UOP_FY_C, UOP_FY_D, UOP_FY_S: tf = ty_reg;
            default:                                tf = tz_reg;
        endcase
    end

    assign tw    = word_t'(tf);
    assign six_t = (tw <<< 2) + (tw <<< 1);
    assign la    = ctl.is2d ? n0_reg : e0_reg;
    assign lb    = ctl.is2d ? n1_reg : e1_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        base  = g0_reg;
        unique case (ctl.uop)
            UOP_FX_A, UOP_FY_A, UOP_FZ_A:
            begin
                mul_a = tw;
                mul_b = six_t - FADE_K15;
            end
            UOP_FX_C, UOP_FY_C, UOP_FZ_C:
            begin
                mul_a = tw;
                mul_b = tw;
            end
            UOP_FX_D, UOP_FY_D, UOP_FZ_D:
            begin
                mul_a = word_t'(fc_reg);
                mul_b = tw;
            end
            UOP_FX_S, UOP_FY_S, UOP_FZ_S:
            begin
                mul_a = word_t'(fc_reg);
                mul_b = fb_reg;
            end
            UOP_MIX_C0, UOP_MIX_C1, UOP_MIX_C2, UOP_MIX_C3:
            begin
                mul_a = word_t'(sx_reg);
                mul_b = word_t'(g1_reg) - word_t'(g0_reg);
                base  = g0_reg;
            end
            UOP_MIX_E0:
            begin
                mul_a = word_t'(sy_reg);
                mul_b = word_t'(cm_reg[1]) - word_t'(cm_reg[0]);
                base  = cm_reg[0];
            end
            UOP_MIX_E1:
            begin
                mul_a = word_t'(sy_reg);
                mul_b = word_t'(cm_reg[3]) - word_t'(cm_reg[2]);
                base  = cm_reg[2];
            end
            UOP_MIX_N:
            begin
                mul_a = word_t'(sz_reg);
                mul_b = word_t'(lb) - word_t'(la);
                base  = la;
            end
            UOP_SCALE:
            begin
                mul_a = word_t'(noise_reg);
                mul_b = $signed(word_t'(inv_amplitude));
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign shifted  = prod_reg >>> Q_BITS;
    assign scaled   = prod_reg >>> AMP_FRAC;
    assign lerp_res = base + mix_t'(shifted);
    assign acc_sum  = (ACC_W + 2)'(acc_in_reg) + scaled[ACC_W+1:0];

    // saturate to the accumulator range
    always_comb
    begin
        if (acc_sum[ACC_W+1:ACC_W-1] == 3'b000 || acc_sum[ACC_W+1:ACC_W-1] == 3'b111)
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        else if (!acc_sum[ACC_W+1])
        begin
            acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wb)
        begin
            unique case (ctl.uop)
                UOP_FX_A, UOP_FY_A, UOP_FZ_A: fb_reg <= word_t'(shifted) + FADE_K10;
                UOP_FX_C, UOP_FY_C, UOP_FZ_C,
                UOP_FX_D, UOP_FY_D, UOP_FZ_D: fc_reg <= coord_t'(shifted);
                UOP_FX_S:   sx_reg <= coord_t'(shifted);
                UOP_FY_S:   sy_reg <= coord_t'(shifted);
                UOP_FZ_S:   sz_reg <= coord_t'(shifted);
                UOP_RD_H0:  h0_reg <= tidx_t'(rdata_reg) + cy_reg;
                UOP_RD_H1:  h1_reg <= tidx_t'(rdata_reg) + cy_reg;
                UOP_RD_P2:  p2_reg <= tidx_t'(rdata_reg) + cz_reg;
                UOP_RD_P3:  p3_reg <= tidx_t'(rdata_reg) + cz_reg;
                UOP_RD_P5:  p5_reg <= tidx_t'(rdata_reg) + cz_reg;
                UOP_RD_P6:  p6_reg <= tidx_t'(rdata_reg) + cz_reg;
                UOP_RD_G00, UOP_RD_G10, UOP_RD_G20, UOP_RD_G30: g0_reg <= grad_val;
                UOP_RD_G01, UOP_RD_G11, UOP_RD_G21, UOP_RD_G31: g1_reg <= grad_val;
                UOP_MIX_C0:
                begin
                    if (ctl.is2d)
                    begin
                        n0_reg <= lerp_res;
                    end
                end
                UOP_MIX_C2:
                begin
                    if (ctl.is2d)
                    begin
                        n1_reg <= lerp_res;
                    end
                end
                UOP_MIX_E0: e0_reg    <= lerp_res;
                UOP_MIX_E1: e1_reg    <= lerp_res;
                UOP_MIX_N:  noise_reg <= lerp_res;
                UOP_SCALE:
                begin
                    accum_out_reg <= acc_sat;
                    noise_out_reg <= noise_reg[NOISE_W-1:0];
                end
                default:
                begin
                    fb_reg <= fb_reg;
                end
            endcase
        end
    end

    // 3d corner cache
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cy_reg <= '0;
            recomp_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                cm_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.capture)
            begin
                recomp_reg <= recomp_now;
                if (!ctl.is2d && recomp_now)
                begin
                    last_cy_reg <= cy_next;
                end
            end
            if (ctl.wb && !ctl.is2d)
            begin
                if (ctl.uop == UOP_MIX_C0)
                begin
                    cm_reg[0] <= lerp_res;
                end
                if (ctl.uop == UOP_MIX_C1)
                begin
                    cm_reg[1] <= lerp_res;
                end
                if (ctl.uop == UOP_MIX_C2)
                begin
                    cm_reg[2] <= lerp_res;
                end
                if (ctl.uop == UOP_MIX_C3)
                begin
                    cm_reg[3] <= lerp_res;
                end
            end
        end
    end

    assign accum_out = accum_out_reg;
    assign noise_out = noise_out_reg;

endmodule

// ----- rtl/perlin_noise_sampler.sv -----
// 3d/2d gradient noise sampler with a fixed-point quintic fade.
// input stream: s_tuser carries the command (load table entry, sample 3d,
// sample 2d), s_tdata the table entry and the sample fields. a load writes the
// table entry and returns nothing; sample transactions return one result on the
// output stream, accumulator plus scaled noise and the raw noise.
// the table must be loaded before sampling. registers on the apb port:
// offset_x, offset_y, offset_z, inv_amplitude at 0x0, 0x4, 0x8, 0xc.
// one sample at a time: a shared multiplier and a single table read port run
// a sequence of steps (each an issue and a writeback); a step is skipped when
// the mode does not need it, in 2d or when the 3d corner cache is reused
// rather than the 3d corners recomputed. s_tready comes back with m_tvalid,
// so a new sample is accepted only once the sequencer is through with the last.
// the result sits in an output register; the next transaction is accepted
// while it waits, and the sequencer holds before its last step while the
// receiver stalls. reset clears the corner cache, the cached y cell, the
// control state and the apb offsets and sets inv_amplitude to 0x10000; the
// other datapath registers and the permutation table keep whatever they held.
module perlin_noise_sampler
    import pns_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,  // table_index, table_value, pos_x, pos_y, pos_z, column_start, accum_in
    input  logic [1:0]   s_tuser,  // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata   // accum_out, noise_out
);

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;
    localparam logic [1:0] REG_INV_AMP  = 2'd3;

    logic [OFF_W-1:0] offset_x_reg, offset_y_reg, offset_z_reg, inv_amp_reg;
    logic cfg_wr;

    ctl_t       ctl;
    dp_status_t status;
    logic signed [ACC_W-1:0]   accum_out;
    logic signed [NOISE_W-1:0] noise_out;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            inv_amp_reg  <= OFF_W'(65536);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_OFFSET_X: offset_x_reg <= pwdata[OFF_W-1:0];
                REG_OFFSET_Y: offset_y_reg <= pwdata[OFF_W-1:0];
                REG_OFFSET_Z: offset_z_reg <= pwdata[OFF_W-1:0];
                REG_INV_AMP:  inv_amp_reg  <= pwdata[OFF_W-1:0];
                default:      inv_amp_reg  <= inv_amp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OFFSET_X: prdata = 32'(offset_x_reg);
            REG_OFFSET_Y: prdata = 32'(offset_y_reg);
            REG_OFFSET_Z: prdata = 32'(offset_z_reg);
            REG_INV_AMP:  prdata = 32'(inv_amp_reg);
            default:      prdata = '0;
        endcase
    end

    pns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .cmd       (s_tuser),
        .out_ready (m_tready),
        .status    (status),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .ctl       (ctl)
    );

    pns_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .offset_x      (offset_x_reg),
        .offset_y      (offset_y_reg),
        .offset_z      (offset_z_reg),
        .inv_amplitude (inv_amp_reg),
        .table_index   (s_tdata[7:0]),
        .table_value   (s_tdata[15:8]),
        .pos_x         (s_tdata[55:16]),
        .pos_y         (s_tdata[95:56]),
        .pos_z         (s_tdata[135:96]),
        .column_start  (s_tdata[136]),
        .accum_in      (s_tdata[184:137]),
        .status        (status),
        .accum_out     (accum_out),
        .noise_out     (noise_out)
    );

    assign m_tdata = {5'b0, noise_out, accum_out};

endmodule
